@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define MBDD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition holds in the cycle after the trigger
`define MBDD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/mbdd_pkg.sv @@
// ----------------------------------------------------------------------------
// mbdd_pkg
// types and constants of the marine bus datagram decoder
// ----------------------------------------------------------------------------
package mbdd_pkg;

   localparam int HEAD_DEPTH = 5;
   localparam int COUNT_W    = 6;

   localparam logic [7:0] CMD_DEPTH       = 8'h00;
   localparam logic [7:0] CMD_WIND_ANGLE  = 8'h10;
   localparam logic [7:0] CMD_WIND_SPEED  = 8'h11;
   localparam logic [7:0] CMD_WATER_SPEED = 8'h20;
   localparam logic [7:0] CMD_TEMPERATURE = 8'h23;

   localparam logic [7:0] MAX_WIND_AGE_RESET = 8'd3;

   typedef enum logic [2:0] {
      KIND_DEPTH       = 3'd0,
      KIND_WIND_ANGLE  = 3'd1,
      KIND_WIND_SPEED  = 3'd2,
      KIND_WATER_SPEED = 3'd3,
      KIND_TEMPERATURE = 3'd4,
      KIND_UNKNOWN     = 3'd5
   } msg_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_LENGTH  = 2'd1,
      STATUS_UNKNOWN = 2'd2
   } status_type;

   typedef logic [HEAD_DEPTH-1:0][7:0] head_type;

   typedef struct packed {
      head_type             head;
      logic [COUNT_W-1:0]   count;
      logic                 overflow;
   } datagram_type;

   typedef struct packed {
      logic [15:0] angle;
      logic [10:0] speed;
      logic [7:0]  angle_stamp;
      logic [7:0]  speed_stamp;
   } wind_state_type;

   typedef struct packed {
      msg_kind_type msg_kind;
      status_type   status;
      logic [15:0]  value_main;
      logic [7:0]   value_extra;
      logic [15:0]  wind_angle_halfdeg;
      logic [10:0]  wind_speed_tenths;
      logic         wind_fresh;
      logic         overflow;
   } result_type;

endpackage

@@ rtl/mbdd_if.sv @@
// ----------------------------------------------------------------------------
// mbdd channel interfaces
// valid/ready channels for characters, results and the age register
// ----------------------------------------------------------------------------
interface mbdd_req_if;
   logic       valid;
   logic       ready;
   logic       is_tick;
   logic       is_command;
   logic [7:0] char_byte;

   modport source (output valid, is_tick, is_command, char_byte, input ready);
   modport sink   (input valid, is_tick, is_command, char_byte, output ready);
endinterface

interface mbdd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  msg_kind;
   logic [1:0]  status;
   logic [15:0] value_main;
   logic [7:0]  value_extra;
   logic [15:0] wind_angle_halfdeg;
   logic [10:0] wind_speed_tenths;
   logic        wind_fresh;
   logic        overflow;

   modport source (output valid, msg_kind, status, value_main, value_extra,
                   wind_angle_halfdeg, wind_speed_tenths, wind_fresh, overflow,
                   input ready);
   modport sink   (input valid, msg_kind, status, value_main, value_extra,
                   wind_angle_halfdeg, wind_speed_tenths, wind_fresh, overflow,
                   output ready);
endinterface

interface mbdd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/mbdd_decode.sv @@
// ----------------------------------------------------------------------------
// mbdd_decode
// checks a finished datagram and decodes it, updating the wind pair
// ----------------------------------------------------------------------------
module mbdd_decode (
   input  mbdd_pkg::datagram_type   dgram_in,
   input  mbdd_pkg::wind_state_type wind_in,
   input  logic [7:0]               tick_time_in,
   input  logic [7:0]               max_age_in,
   output mbdd_pkg::result_type     result_out,
   output mbdd_pkg::wind_state_type wind_out
);

   mbdd_pkg::msg_kind_type kind;
   logic [7:0]             b1, b2, b3, b4;
   logic [8:0]             want;
   logic                   length_ok;
   logic [10:0]            speed_calc;
   logic [7:0]             angle_age;
   logic [7:0]             speed_age;

   always_comb begin
      b1 = dgram_in.head[1];
      b2 = dgram_in.head[2];
      b3 = dgram_in.head[3];
      b4 = dgram_in.head[4];

      unique case (dgram_in.head[0])
         mbdd_pkg::CMD_DEPTH:       kind = mbdd_pkg::KIND_DEPTH;
         mbdd_pkg::CMD_WIND_ANGLE:  kind = mbdd_pkg::KIND_WIND_ANGLE;
         mbdd_pkg::CMD_WIND_SPEED:  kind = mbdd_pkg::KIND_WIND_SPEED;
         mbdd_pkg::CMD_WATER_SPEED: kind = mbdd_pkg::KIND_WATER_SPEED;
         mbdd_pkg::CMD_TEMPERATURE: kind = mbdd_pkg::KIND_TEMPERATURE;
         default:                   kind = mbdd_pkg::KIND_UNKNOWN;
      endcase

      // temperature only carries the length in the low two attribute bits
      if (kind == mbdd_pkg::KIND_TEMPERATURE) begin
         want = {7'd0, b1[1:0]} + 9'd3;
      end else begin
         want = {1'b0, b1} + 9'd3;
      end
      length_ok = !dgram_in.overflow && ({3'd0, dgram_in.count} == want);

      // times ten as shift and add
      speed_calc = {1'b0, b2[6:0], 3'b000} + {3'b000, b2[6:0], 1'b0}
                 + {7'd0, b3[3:0]};

      wind_out                = wind_in;
      result_out.msg_kind     = kind;
      result_out.status       = mbdd_pkg::STATUS_OK;
      result_out.value_main   = 16'd0;
      result_out.value_extra  = 8'd0;

      if (kind == mbdd_pkg::KIND_UNKNOWN) begin
         result_out.status = mbdd_pkg::STATUS_UNKNOWN;
      end else if (!length_ok) begin
         result_out.status = mbdd_pkg::STATUS_LENGTH;
      end else begin
         unique case (kind)
            mbdd_pkg::KIND_DEPTH: begin
               result_out.value_main = {b4, b3};
            end
            mbdd_pkg::KIND_WIND_ANGLE: begin
               result_out.value_main = {b2, b3};
               wind_out.angle        = {b2, b3};
               wind_out.angle_stamp  = tick_time_in;
            end
            mbdd_pkg::KIND_WIND_SPEED: begin
               result_out.value_main = {5'd0, speed_calc};
               wind_out.speed        = speed_calc;
               wind_out.speed_stamp  = tick_time_in;
            end
            mbdd_pkg::KIND_WATER_SPEED: begin
               result_out.value_main = {b3, b2};
            end
            default: begin
               result_out.value_main  = {8'd0, b2};
               result_out.value_extra = b3;
            end
         endcase
      end

      angle_age = tick_time_in - wind_out.angle_stamp;
      speed_age = tick_time_in - wind_out.speed_stamp;

      result_out.wind_angle_halfdeg = wind_out.angle;
      result_out.wind_speed_tenths  = wind_out.speed;
      result_out.wind_fresh         = (angle_age < max_age_in) && (speed_age < max_age_in);
      result_out.overflow           = dgram_in.overflow;
   end

endmodule

@@ rtl/marine_bus_datagram_decoder_top.sv @@
// ----------------------------------------------------------------------------
// marine_bus_datagram_decoder_top
// Decodes instrument bus datagrams from 9-bit characters and time ticks.
// One beat is taken every clock cycle unless stalled; a command beat that
// closes an open datagram is checked and decoded in the cycle it is taken
// and its result sits in the output register from the next cycle on. The
// input stalls only while that register holds a result the sink has not
// taken. The wind age register is written at any time the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module marine_bus_datagram_decoder_top #(
   parameter int MAX_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   mbdd_req_if.sink    req_bus,
   mbdd_rsp_if.source  rsp_bus,
   mbdd_csr_if.sink    csr_bus
);

   localparam logic [mbdd_pkg::COUNT_W-1:0] MaxCount = mbdd_pkg::COUNT_W'(MAX_BYTES);
   localparam logic [mbdd_pkg::COUNT_W-1:0] HeadCount =
      mbdd_pkg::COUNT_W'(mbdd_pkg::HEAD_DEPTH);

   logic [7:0]                   max_age_ff, max_age_in;
   mbdd_pkg::head_type           head_ff, head_in;
   logic [mbdd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         have_ff, have_in;
   logic                         ovf_ff, ovf_in;
   logic [7:0]                   tick_ff, tick_in;
   mbdd_pkg::wind_state_type     wind_ff, wind_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   mbdd_pkg::result_type         result_ff, result_in;

   mbdd_pkg::datagram_type       dgram;
   mbdd_pkg::wind_state_type     wind_next;
   mbdd_pkg::result_type         decoded;
   logic                         accept;
   logic                         finish;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign finish        = accept && !req_bus.is_tick && req_bus.is_command && have_ff;

   assign dgram = {head_ff, count_ff, ovf_ff};

   mbdd_decode u_decode (
      .dgram_in     (dgram),
      .wind_in      (wind_ff),
      .tick_time_in (tick_ff),
      .max_age_in   (max_age_ff),
      .result_out   (decoded),
      .wind_out     (wind_next)
   );

   always_comb begin
      max_age_in   = csr_bus.valid ? csr_bus.data : max_age_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      have_in      = have_ff;
      ovf_in       = ovf_ff;
      tick_in      = tick_ff;
      wind_in      = wind_ff;
      result_in    = finish ? decoded : result_ff;
      rsp_valid_in = finish || (rsp_valid_ff && !rsp_bus.ready);

      if (accept) begin
         if (req_bus.is_tick) begin
            tick_in = tick_ff + 8'd1;
         end else if (req_bus.is_command) begin
            if (have_ff) begin
               wind_in = wind_next;
            end
            head_in    = '0;
            head_in[0] = req_bus.char_byte;
            count_in   = mbdd_pkg::COUNT_W'(1);
            ovf_in     = 1'b0;
            have_in    = 1'b1;
         end else if (have_ff) begin
            if (count_ff >= MaxCount) begin
               ovf_in = 1'b1;
            end else begin
               if (count_ff < HeadCount) begin
                  head_in[count_ff[2:0]] = req_bus.char_byte;
               end
               count_in = count_ff + mbdd_pkg::COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff   <= head_in;
      result_ff <= result_in;
      if (reset) begin
         max_age_ff   <= mbdd_pkg::MAX_WIND_AGE_RESET;
         count_ff     <= '0;
         have_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         tick_ff      <= '0;
         wind_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_age_ff   <= max_age_in;
         count_ff     <= count_in;
         have_ff      <= have_in;
         ovf_ff       <= ovf_in;
         tick_ff      <= tick_in;
         wind_ff      <= wind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.msg_kind           = result_ff.msg_kind;
   assign rsp_bus.status             = result_ff.status;
   assign rsp_bus.value_main         = result_ff.value_main;
   assign rsp_bus.value_extra        = result_ff.value_extra;
   assign rsp_bus.wind_angle_halfdeg = result_ff.wind_angle_halfdeg;
   assign rsp_bus.wind_speed_tenths  = result_ff.wind_speed_tenths;
   assign rsp_bus.wind_fresh         = result_ff.wind_fresh;
   assign rsp_bus.overflow           = result_ff.overflow;

   `MBDD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= MaxCount)
   `MBDD_ASSERT_NOW(a_ovf_at_limit, clock, reset, ovf_ff, count_ff == MaxCount && have_ff)
   `MBDD_ASSERT_NOW(a_idle_empty, clock, reset, !have_ff, count_ff == '0 && !ovf_ff)
   `MBDD_ASSERT_NOW(a_rsp_from_cmd, clock, reset, $rose(rsp_valid_ff), $past(finish))

endmodule
